// File: sv/ll1tp_pkg.sv
`timescale 1ns / 1ps
package ll1tp_pkg;

  localparam int STACK_DEPTH     = 1024;
  localparam int STK_AW          = $clog2(STACK_DEPTH);
  localparam int SP_W            = STK_AW + 1;
  localparam int SYM_W           = 6;
  localparam int NUM_SYMBOLS     = 1 << SYM_W;
  localparam int TBL_AW          = 2 * SYM_W;
  localparam int TBL_DEPTH       = 1 << TBL_AW;
  localparam int PROD_W          = 6;
  localparam int NUM_PRODUCTIONS = 1 << PROD_W;
  localparam int MAX_RHS         = 8;
  localparam int POS_W           = 3;
  localparam int LEN_W           = 4;
  localparam int RHS_AW          = PROD_W + POS_W;
  localparam int RHS_DEPTH       = 1 << RHS_AW;
  localparam int CNT_W           = 6;
  localparam logic [CNT_W-1:0] RESULT_LAST = CNT_W'(63);

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_TABLE   = 3'd1,
    OP_RHS_SYM = 3'd2,
    OP_RHS_LEN = 3'd3,
    OP_TOKEN   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    K_EXPAND   = 3'd0,
    K_MATCH    = 3'd1,
    K_ACCEPT   = 3'd2,
    K_MISMATCH = 3'd3,
    K_NOENTRY  = 3'd4,
    K_OVERFLOW = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_RDTOP, S_TOP, S_TBL, S_LEN, S_POP, S_PRD, S_PWR, S_EMIT
  } state_e;

  typedef enum logic {
    CFG_FIRST_NT = 1'b0,
    CFG_START    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [SYM_W-1:0]  nonterminal;
    logic [SYM_W-1:0]  terminal;
    logic [PROD_W-1:0] production;
    logic [POS_W-1:0]  position;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  rhs_length;
    logic [SYM_W-1:0]  token;
  } in_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SYM_W-1:0]  expanded;
    logic [PROD_W-1:0] applied;
    logic [SYM_W-1:0]  top_symbol;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [SP_W-1:0] a;
    logic [SP_W-1:0] b;
    logic            sub;
  } alu_req_t;

  typedef struct packed {
    logic [SP_W-1:0] res;
    logic            over;
  } alu_rsp_t;

endpackage

// File: sv/ll1_table_driven_parser.sv
`timescale 1ns / 1ps
// ll1 predictive parser: load words fill the parse table, rhs symbols and rhs
// lengths in their accept cycle; a start word writes the end marker and then
// the start symbol; a token word walks the symbol stack under a small sequencer
// around one shared pointer adder. a token expands the nonterminal on top, one
// stack access at a time, until a terminal is on top and is tested against it;
// a missing entry or an overflow ends the token. each result goes to the output
// register, held while that register is stalled; a token outside a running
// parse is ignored. after reset the parse table is cleared one entry a cycle,
// all 4096 entries, with in_stall_o high; config writes are taken at any time.
module ll1_table_driven_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ll1tp_pkg::in_t      in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ll1tp_pkg::out_t     out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [5:0]          cfg_data_i
);

  localparam int SW = ll1tp_pkg::SYM_W;
  localparam int PW = ll1tp_pkg::PROD_W;
  localparam int SPW = ll1tp_pkg::SP_W;

  ll1tp_pkg::state_e state_q, state_d;
  ll1tp_pkg::phase_e phase_q, phase_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [SW-1:0] first_nt_q, start_sym_q;
  logic [SW-1:0] tok_q, tok_d, top_q, top_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [ll1tp_pkg::LEN_W-1:0] idx_q, idx_d;
  logic [ll1tp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  ll1tp_pkg::out_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [ll1tp_pkg::TBL_AW:0] clr_q;
  logic clearing;
  logic [ll1tp_pkg::NUM_PRODUCTIONS-1:0] len_vld_q;
  logic len_vld_rd_q;

  // memory ports
  logic stk_we;
  logic [ll1tp_pkg::STK_AW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;
  logic tbl_we;
  logic [ll1tp_pkg::TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [PW-1:0] tbl_wdata, tbl_rdata;
  logic rhs_we;
  logic [ll1tp_pkg::RHS_AW-1:0] rhs_waddr, rhs_raddr;
  logic [SW-1:0] rhs_rdata;
  logic len_we;
  logic [PW-1:0] len_raddr;
  logic [ll1tp_pkg::LEN_W-1:0] len_wdata, len_rdata, len_eff;

  ll1tp_pkg::alu_req_t alu_req;
  ll1tp_pkg::alu_rsp_t alu_rsp;

  logic in_acc, out_free, is_term;

  assign clearing    = ~clr_q[ll1tp_pkg::TBL_AW];
  assign in_stall_o  = clearing || (state_q != ll1tp_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign len_eff     = len_vld_rd_q ? len_rdata : '0;
  assign is_term     = (stk_rdata == '0) || (stk_rdata < first_nt_q);

  ll1tp_ram #(.WIDTH(SW), .DEPTH(ll1tp_pkg::STACK_DEPTH)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  ll1tp_ram #(.WIDTH(PW), .DEPTH(ll1tp_pkg::TBL_DEPTH)) u_table (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr), .rdata_o(tbl_rdata)
  );

  ll1tp_ram #(.WIDTH(SW), .DEPTH(ll1tp_pkg::RHS_DEPTH)) u_rhs (
    .clk_i, .we_i(rhs_we), .waddr_i(rhs_waddr), .wdata_i(in_word_i.symbol),
    .raddr_i(rhs_raddr), .rdata_o(rhs_rdata)
  );

  ll1tp_ram #(.WIDTH(ll1tp_pkg::LEN_W), .DEPTH(ll1tp_pkg::NUM_PRODUCTIONS)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(in_word_i.production), .wdata_i(len_wdata),
    .raddr_i(len_raddr), .rdata_o(len_rdata)
  );

  ll1tp_alu u_alu (
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  // load writes happen in the accept cycle; the table clear owns its port after reset
  always_comb begin
    tbl_we    = clearing || (in_acc && in_word_i.op == ll1tp_pkg::OP_TABLE);
    tbl_waddr = clearing ? clr_q[ll1tp_pkg::TBL_AW-1:0]
                         : {in_word_i.nonterminal, in_word_i.terminal};
    tbl_wdata = clearing ? '0 : in_word_i.production;
    rhs_we    = in_acc && in_word_i.op == ll1tp_pkg::OP_RHS_SYM;
    rhs_waddr = {in_word_i.production, in_word_i.position};
    len_we    = in_acc && in_word_i.op == ll1tp_pkg::OP_RHS_LEN;
    len_wdata = (in_word_i.rhs_length > ll1tp_pkg::LEN_W'(ll1tp_pkg::MAX_RHS))
                ? ll1tp_pkg::LEN_W'(ll1tp_pkg::MAX_RHS) : in_word_i.rhs_length;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    sp_d        = sp_q;
    tok_d       = tok_q;
    top_d       = top_q;
    prod_d      = prod_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    stk_we      = 1'b0;
    stk_waddr   = '0;
    stk_wdata   = '0;
    stk_raddr   = '0;
    tbl_raddr   = {stk_rdata, tok_q};
    rhs_raddr   = {prod_q, 3'(idx_q - 1'b1)};
    len_raddr   = tbl_rdata;
    alu_req.a   = sp_q;
    alu_req.b   = SPW'(1);
    alu_req.sub = 1'b1;

    unique case (state_q)
      ll1tp_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_word_i.op)
            ll1tp_pkg::OP_START: begin
              // end marker at the bottom, start symbol goes in next cycle
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = '0;
              sp_d      = SPW'(2);
              phase_d   = ll1tp_pkg::PH_RUN;
              state_d   = ll1tp_pkg::S_START;
            end
            ll1tp_pkg::OP_TOKEN: begin
              if (phase_q == ll1tp_pkg::PH_RUN) begin
                tok_d   = in_word_i.token;
                cnt_d   = '0;
                state_d = ll1tp_pkg::S_RDTOP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ll1tp_pkg::S_START: begin
        stk_we    = 1'b1;
        stk_waddr = ll1tp_pkg::STK_AW'(1);
        stk_wdata = start_sym_q;
        state_d   = ll1tp_pkg::S_IDLE;
      end
      ll1tp_pkg::S_RDTOP: begin
        stk_raddr = alu_rsp.res[ll1tp_pkg::STK_AW-1:0];
        if (sp_q == '0) begin
          res_d   = '{kind: ll1tp_pkg::K_MISMATCH, expanded: '0, applied: '0,
                      top_symbol: '0, last: 1'b1};
          phase_d = ll1tp_pkg::PH_DONE;
          state_d = ll1tp_pkg::S_EMIT;
        end else begin
          state_d = ll1tp_pkg::S_TOP;
        end
      end
      ll1tp_pkg::S_TOP: begin
        top_d = stk_rdata;
        if (is_term) begin
          res_d = '{kind: ll1tp_pkg::K_MISMATCH, expanded: '0, applied: '0,
                    top_symbol: stk_rdata, last: 1'b1};
          if (stk_rdata == tok_q) begin
            sp_d = alu_rsp.res;
            if (stk_rdata == '0) begin
              res_d.kind = ll1tp_pkg::K_ACCEPT;
              phase_d    = ll1tp_pkg::PH_DONE;
            end else begin
              res_d.kind = ll1tp_pkg::K_MATCH;
            end
          end else begin
            phase_d = ll1tp_pkg::PH_DONE;
          end
          state_d = ll1tp_pkg::S_EMIT;
        end else begin
          state_d = ll1tp_pkg::S_TBL;
        end
      end
      ll1tp_pkg::S_TBL: begin
        prod_d = tbl_rdata;
        if (tbl_rdata == '0) begin
          res_d   = '{kind: ll1tp_pkg::K_NOENTRY, expanded: '0, applied: '0,
                      top_symbol: top_q, last: 1'b1};
          phase_d = ll1tp_pkg::PH_DONE;
          state_d = ll1tp_pkg::S_EMIT;
        end else begin
          state_d = ll1tp_pkg::S_LEN;
        end
      end
      ll1tp_pkg::S_LEN: begin
        alu_req.b   = SPW'(len_eff);
        alu_req.sub = 1'b0;
        idx_d       = len_eff;
        if (cnt_q == ll1tp_pkg::RESULT_LAST || alu_rsp.over) begin
          res_d   = '{kind: ll1tp_pkg::K_OVERFLOW, expanded: '0, applied: '0,
                      top_symbol: top_q, last: 1'b1};
          phase_d = ll1tp_pkg::PH_DONE;
          state_d = ll1tp_pkg::S_EMIT;
        end else begin
          state_d = ll1tp_pkg::S_POP;
        end
      end
      ll1tp_pkg::S_POP: begin
        sp_d  = alu_rsp.res;
        res_d = '{kind: ll1tp_pkg::K_EXPAND, expanded: top_q, applied: prod_q,
                  top_symbol: '0, last: 1'b0};
        state_d = (idx_q == '0) ? ll1tp_pkg::S_EMIT : ll1tp_pkg::S_PRD;
      end
      ll1tp_pkg::S_PRD: begin
        // rhs read issued from rhs_raddr, last symbol first
        state_d = ll1tp_pkg::S_PWR;
      end
      ll1tp_pkg::S_PWR: begin
        alu_req.sub = 1'b0;
        stk_we    = 1'b1;
        stk_waddr = sp_q[ll1tp_pkg::STK_AW-1:0];
        stk_wdata = rhs_rdata;
        sp_d      = alu_rsp.res;
        idx_d     = idx_q - 1'b1;
        state_d   = (idx_q == ll1tp_pkg::LEN_W'(1)) ? ll1tp_pkg::S_EMIT : ll1tp_pkg::S_PRD;
      end
      ll1tp_pkg::S_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          cnt_d       = cnt_q + 1'b1;
          state_d     = res_q.last ? ll1tp_pkg::S_IDLE : ll1tp_pkg::S_RDTOP;
        end
      end
      default: begin
        state_d = ll1tp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ll1tp_pkg::S_IDLE;
      phase_q     <= ll1tp_pkg::PH_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      len_vld_q   <= '0;
      first_nt_q  <= SW'(32);
      start_sym_q <= SW'(32);
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (clearing) begin
        clr_q <= clr_q + 1'b1;
      end
      if (len_we) begin
        len_vld_q[in_word_i.production] <= 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ll1tp_pkg::CFG_FIRST_NT: first_nt_q  <= cfg_data_i;
          ll1tp_pkg::CFG_START:    start_sym_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tok_q        <= tok_d;
    top_q        <= top_d;
    prod_q       <= prod_d;
    idx_q        <= idx_d;
    res_q        <= res_d;
    out_q        <= out_d;
    len_vld_rd_q <= len_vld_q[len_raddr];
  end

`ifndef ASSERT_OFF
  // stack never grows past its depth
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(ll1tp_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // only expansions continue a token
  a_expand_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ll1tp_pkg::S_EMIT && res_q.kind == ll1tp_pkg::K_EXPAND) |-> !res_q.last)
    else $error("expansion marked last");

  // a length lookup only follows a real table entry
  a_len_has_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ll1tp_pkg::S_LEN) |-> prod_q != '0)
    else $error("length lookup without production");
`endif

endmodule

// File: sv/ll1tp_ram.sv
`timescale 1ns / 1ps
module ll1tp_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/ll1tp_alu.sv
`timescale 1ns / 1ps
module ll1tp_alu (
  input  ll1tp_pkg::alu_req_t req_i,
  output ll1tp_pkg::alu_rsp_t rsp_o
);

  logic [ll1tp_pkg::SP_W:0] wide;

  // shared stack pointer adder; over flags a push beyond depth (sp + len > depth + 1)
  always_comb begin
    if (req_i.sub) begin
      wide = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      wide = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    rsp_o.res  = wide[ll1tp_pkg::SP_W-1:0];
    rsp_o.over = wide > (ll1tp_pkg::SP_W + 1)'(ll1tp_pkg::STACK_DEPTH + 1);
  end

endmodule
